// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

	// Field widths of the job and result beats
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;
	localparam int TICK_W = 21;
	localparam int PIDX_W = 5;

	typedef logic [ARR_W-1:0]  arr_t;
	typedef logic [BUR_W-1:0]  bur_t;
	typedef logic [PRI_W-1:0]  pri_t;
	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [PIDX_W-1:0] pidx_t;

	// One process as loaded by the host
	typedef struct packed {
		arr_t arrival_time;
		bur_t burst_length;
		pri_t priority_level;
		logic last_process;
	} pps_job_t;

	// One result per process
	typedef struct packed {
		pidx_t process_index;
		tick_t completion_time;
		tick_t turnaround_time;
		tick_t waiting_time;
		logic  last_result;
	} pps_result_t;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic  token;
		logic  best_vld;
		pri_t  best_prio;
		arr_t  best_arr;
		pidx_t best_idx;
		bur_t  best_rem;
		logic  nxt_vld;
		arr_t  nxt_arr;
	} pps_cand_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic  load;
		pidx_t load_idx;
		arr_t  arrival;
		bur_t  burst;
		pri_t  prio;
		logic  apply;
		pidx_t sel;
		bur_t  run;
		logic  finish;
		tick_t done_tick;
		tick_t tick;
		pidx_t count;
	} pps_ctl_t;

	// Per-cell figures read out after the simulation
	typedef struct packed {
		tick_t completion;
		tick_t turnaround;
		tick_t waiting;
	} pps_cres_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_APPLY,
		S_FIN1,
		S_FIN2,
		S_OUT
	} pps_state_t;

endpackage

// ===== hw/rtl/pps_if.sv =====
interface pps_job_if import pps_pkg::*; ();
	logic     valid;
	logic     ready;
	pps_job_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pps_result_if import pps_pkg::*; ();
	logic        valid;
	logic        ready;
	pps_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler. The host loads one process per beat on job
// (up to MAX_PROCESSES; extra beats are dropped, but a last beat still starts
// the run). The beat with last_process set starts a simulation from tick zero
// in a row of MAX_PROCESSES cells, one per process. Each scheduling decision
// is one scan token passed down the row, then a decide state and, when a
// process is chosen, an apply state. A decision runs the chosen process until
// it finishes or until the next pending arrival, or jumps idle time to that
// arrival, so a set takes at most about 3*MAX_PROCESSES decisions. The FIN1
// and FIN2 states then let the figures settle, and one result beat per process
// goes out on result as the sink takes it. job is not ready from the last
// beat until the final result has been taken into the output register.
module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int unsigned MAX_PROCESSES = 16
) (
	input  logic clk,
	input  logic arst_n,
	pps_job_if.sink      job,
	pps_result_if.source result
);

	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam pidx_t MAX_CNT = pidx_t'(MAX_PROCESSES);

	pps_state_t state_q;
	pps_state_t state_d;

	pidx_t load_cnt_q;
	pidx_t fin_cnt_q;
	pidx_t out_idx_q;
	tick_t tick_q;
	logic  scan_start_q;
	logic  res_vld_q;

	pps_cand_t   sc_q;
	bur_t        run_q;
	logic        fin_q;
	pidx_t       sel_q;
	pps_result_t res_q;

	pps_ctl_t  ctl;
	pps_cand_t cand_w [MAX_PROCESSES+1];
	pps_cres_t cres_w [MAX_PROCESSES];

	logic  job_take;
	logic  res_take;
	logic  res_last;
	logic  scan_done;
	logic  last_fin;
	tick_t diff;
	logic  cut;

	// Row of process cells
	assign cand_w[0] = '{token: scan_start_q, best_vld: 1'b0, best_prio: '0, best_arr: '0,
		best_idx: '0, best_rem: '0, nxt_vld: 1'b0, nxt_arr: '0};

	for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
		pps_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cand_in  (cand_w[i]),
			.cand_out (cand_w[i+1]),
			.cres     (cres_w[i])
		);
	end

	assign job_take  = job.valid && job.ready;
	assign res_take  = !res_vld_q || result.ready;
	assign res_last  = (pidx_t'(out_idx_q + 1'b1) == load_cnt_q);
	assign scan_done = cand_w[MAX_PROCESSES].token;
	assign last_fin  = fin_q && (pidx_t'(fin_cnt_q + 1'b1) == load_cnt_q);

	// Run length: until finish or until the next pending arrival
	assign diff = {{(TICK_W-ARR_W){1'b0}}, sc_q.nxt_arr} - tick_q;
	assign cut  = sc_q.nxt_vld && (diff < {{(TICK_W-BUR_W){1'b0}}, sc_q.best_rem});

	// Broadcast to the cells
	always_comb begin
		ctl.load      = job_take && (load_cnt_q < MAX_CNT);
		ctl.load_idx  = load_cnt_q;
		ctl.arrival   = job.data.arrival_time;
		ctl.burst     = job.data.burst_length;
		ctl.prio      = job.data.priority_level;
		ctl.apply     = (state_q == S_APPLY);
		ctl.sel       = sel_q;
		ctl.run       = run_q;
		ctl.finish    = fin_q;
		ctl.done_tick = tick_q + {{(TICK_W-BUR_W){1'b0}}, run_q};
		ctl.tick      = tick_q;
		ctl.count     = load_cnt_q;
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		job.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				job.ready = 1'b1;
				if (job.valid && job.data.last_process) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (sc_q.best_vld) begin
					state_d = S_APPLY;
				end else if (sc_q.nxt_vld) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_FIN1;
				end
			end
			S_APPLY: begin
				state_d = last_fin ? S_FIN1 : S_SCAN;
			end
			S_FIN1: state_d = S_FIN2;
			S_FIN2: state_d = S_OUT;
			S_OUT: begin
				if (res_take && res_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			load_cnt_q   <= '0;
			fin_cnt_q    <= '0;
			out_idx_q    <= '0;
			tick_q       <= '0;
			scan_start_q <= 1'b0;
			res_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			scan_start_q <= (state_d == S_SCAN) && (state_q != S_SCAN);
			if (ctl.load) begin
				load_cnt_q <= pidx_t'(load_cnt_q + 1'b1);
			end
			if (job_take && job.data.last_process) begin
				tick_q    <= '0;
				fin_cnt_q <= '0;
				out_idx_q <= '0;
			end
			// Idle jump to the next arrival
			if ((state_q == S_DECIDE) && !sc_q.best_vld && sc_q.nxt_vld) begin
				tick_q <= {{(TICK_W-ARR_W){1'b0}}, sc_q.nxt_arr};
			end
			if (state_q == S_APPLY) begin
				tick_q <= ctl.done_tick;
				if (fin_q) begin
					fin_cnt_q <= pidx_t'(fin_cnt_q + 1'b1);
				end
			end
			// Result beats in load order
			if ((state_q == S_OUT) && res_take) begin
				res_vld_q <= 1'b1;
				out_idx_q <= pidx_t'(out_idx_q + 1'b1);
				if (res_last) begin
					load_cnt_q <= '0;
				end
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && scan_done) begin
			sc_q <= cand_w[MAX_PROCESSES];
		end
		if (state_q == S_DECIDE) begin
			sel_q <= sc_q.best_idx;
			fin_q <= !cut;
			run_q <= cut ? diff[BUR_W-1:0] : sc_q.best_rem;
		end
		if ((state_q == S_OUT) && res_take) begin
			res_q.process_index   <= pidx_t'(out_idx_q + 1'b1);
			res_q.completion_time <= cres_w[out_idx_q[IDX_W-1:0]].completion;
			res_q.turnaround_time <= cres_w[out_idx_q[IDX_W-1:0]].turnaround;
			res_q.waiting_time    <= cres_w[out_idx_q[IDX_W-1:0]].waiting;
			res_q.last_result     <= res_last;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;

	// Checks
	a_fin_le_load: assert property (@(posedge clk) disable iff (!arst_n)
		fin_cnt_q <= load_cnt_q || state_q == S_IDLE)
		else $error("finished count exceeds loaded count");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |-> run_q != '0)
		else $error("zero-length service step");

	a_tick_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |=> tick_q > $past(tick_q))
		else $error("tick did not advance on service");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == S_SCAN)
		else $error("scan token outside scan");

endmodule

// ===== hw/rtl/pps_cell.sv =====
module pps_cell import pps_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pps_ctl_t  ctl,
	input  pps_cand_t cand_in,
	output pps_cand_t cand_out,
	output pps_cres_t cres
);

	arr_t  arr_q;
	bur_t  burst_q;
	pri_t  prio_q;
	bur_t  rem_q;
	tick_t comp_q;
	tick_t tat_q;
	tick_t wt_q;
	logic  token_q;
	pps_cand_t cand_q;
	pps_cand_t cand_d;

	logic  mine;
	logic  active;
	logic  is_ready;
	logic  is_future;
	logic  better;

	assign mine      = 1'b1;
	assign active    = (pidx_t'(IDX) < ctl.count) && (rem_q != '0) && mine;
	assign is_ready  = active && ({{(TICK_W-ARR_W){1'b0}}, arr_q} <= ctl.tick);
	assign is_future = active && ({{(TICK_W-ARR_W){1'b0}}, arr_q} > ctl.tick);
	assign better    = is_ready && (!cand_in.best_vld || (prio_q < cand_in.best_prio) ||
		((prio_q == cand_in.best_prio) && (arr_q < cand_in.best_arr)));

	// Merge this cell into the passing candidate; earlier cells win ties
	always_comb begin
		cand_d = cand_in;
		if (better) begin
			cand_d.best_vld  = 1'b1;
			cand_d.best_prio = prio_q;
			cand_d.best_arr  = arr_q;
			cand_d.best_idx  = pidx_t'(IDX);
			cand_d.best_rem  = rem_q;
		end
		if (is_future && (!cand_in.nxt_vld || (arr_q < cand_in.nxt_arr))) begin
			cand_d.nxt_vld = 1'b1;
			cand_d.nxt_arr = arr_q;
		end
	end

	// Token bit of the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			token_q <= cand_in.token;
		end
	end

	// Hand the candidate to the next cell
	always_ff @(posedge clk) begin
		cand_q <= cand_d;
	end

	// Load, serve and finish this process
	always_ff @(posedge clk) begin
		if (ctl.load && (ctl.load_idx == pidx_t'(IDX))) begin
			arr_q   <= ctl.arrival;
			prio_q  <= ctl.prio;
			burst_q <= (ctl.burst == '0) ? bur_t'(1) : ctl.burst;
			rem_q   <= (ctl.burst == '0) ? bur_t'(1) : ctl.burst;
		end else if (ctl.apply && (ctl.sel == pidx_t'(IDX))) begin
			rem_q <= rem_q - ctl.run;
		end
		if (ctl.apply && ctl.finish && (ctl.sel == pidx_t'(IDX))) begin
			comp_q <= ctl.done_tick;
		end
		// Derive turnaround in tat_q, then waiting in wt_q from it
		tat_q <= comp_q - {{(TICK_W-ARR_W){1'b0}}, arr_q};
		wt_q  <= tat_q - {{(TICK_W-BUR_W){1'b0}}, burst_q};
	end

	always_comb begin
		cand_out       = cand_q;
		cand_out.token = token_q;
	end

	assign cres.completion = comp_q;
	assign cres.turnaround = tat_q;
	assign cres.waiting    = wt_q;

endmodule

// ===== dv/preemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 100ps

module preemptive_priority_scheduler_tb;
	import pps_pkg::*;

	localparam int MAX_JOBS    = 16;
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYC  = 60;
	localparam int RAND_BEATS  = 350;

	typedef struct {
		pps_job_t job;
		bit       hold;
	} queued_job_t;

	logic clk;
	logic arst_n;

	pps_job_if    job_ch ();
	pps_result_if res_ch ();

	preemptive_priority_scheduler #(
		.MAX_PROCESSES(MAX_JOBS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.job(job_ch),
		.result(res_ch)
	);

	// Beats still to be sent and per-process statistics still to arrive
	queued_job_t job_queue [$];
	pps_result_t stats_pending [$];
	queued_job_t head_job;

	// Process set being loaded, as the scheduler should see it
	arr_t set_arrival [MAX_JOBS];
	bur_t set_burst [MAX_JOBS];
	pri_t set_prio [MAX_JOBS];
	int   set_count;
	bit   set_overflowed;

	int beats_sent;
	int stats_seen;
	int sets_run;
	int overflow_sets;
	int mismatches;
	int quiet_cycles;
	pps_result_t want;
	bit field_bad;

	task automatic add_job(input int arr, input int bur, input int pri, input bit last,
			input bit hold = 1'b0);
		queued_job_t q;
		q.job.arrival_time   = arr_t'(arr);
		q.job.burst_length   = bur_t'(bur);
		q.job.priority_level = pri_t'(pri);
		q.job.last_process   = last;
		q.hold               = hold;
		job_queue.push_back(q);
	endtask

	// Schedule the loaded set, jumping from event to event, and queue
	// the completion, turnaround and waiting time of every process
	function automatic void run_schedule();
		int unsigned rem [MAX_JOBS];
		int unsigned done_at [MAX_JOBS];
		int unsigned now;
		int unsigned horizon;
		int finished;
		int pick;
		pps_result_t stat;
		for (int i = 0; i < set_count; i++) begin
			rem[i] = set_burst[i];
			done_at[i] = 0;
		end
		now = 0;
		finished = 0;
		while (finished < set_count) begin
			pick = -1;
			for (int i = 0; i < set_count; i++) begin
				if (rem[i] != 0 && set_arrival[i] <= now) begin
					if (pick < 0 || set_prio[i] < set_prio[pick] ||
							(set_prio[i] == set_prio[pick] &&
							set_arrival[i] < set_arrival[pick]))
						pick = i;
				end
			end
			if (pick < 0) begin
				// nothing ready: jump to the earliest pending arrival
				horizon = 32'hFFFF_FFFF;
				for (int i = 0; i < set_count; i++)
					if (rem[i] != 0 && set_arrival[i] < horizon)
						horizon = set_arrival[i];
				now = horizon;
			end else begin
				// run the pick until it ends or a new arrival may preempt it
				horizon = now + rem[pick];
				for (int i = 0; i < set_count; i++)
					if (rem[i] != 0 && set_arrival[i] > now && set_arrival[i] < horizon)
						horizon = set_arrival[i];
				rem[pick] -= horizon - now;
				now = horizon;
				if (rem[pick] == 0) begin
					done_at[pick] = now;
					finished++;
				end
			end
		end
		for (int i = 0; i < set_count; i++) begin
			stat.process_index   = pidx_t'(i + 1);
			stat.completion_time = tick_t'(done_at[i]);
			stat.turnaround_time = stat.completion_time - tick_t'(set_arrival[i]);
			stat.waiting_time    = stat.turnaround_time - tick_t'(set_burst[i]);
			stat.last_result     = (i == set_count - 1);
			stats_pending.push_back(stat);
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Driver: present queued beats, idle at random, hold where asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_ch.valid <= 1'b0;
			job_ch.data  <= '0;
		end else begin
			if (job_ch.valid && job_ch.ready) begin
				beats_sent++;
				if (set_count < MAX_JOBS) begin
					set_arrival[set_count] = job_ch.data.arrival_time;
					set_burst[set_count]   = (job_ch.data.burst_length == '0) ?
						bur_t'(1) : job_ch.data.burst_length;
					set_prio[set_count]    = job_ch.data.priority_level;
					set_count++;
				end else begin
					set_overflowed = 1'b1;
				end
				if (job_ch.data.last_process) begin
					run_schedule();
					sets_run++;
					if (set_overflowed)
						overflow_sets++;
					set_count = 0;
					set_overflowed = 1'b0;
				end
			end
			if (!job_ch.valid || job_ch.ready) begin
				if (job_queue.size() > 0 &&
						!(job_queue[0].hold && stats_pending.size() > 0) &&
						((beats_sent >= 150 && beats_sent < 230) ||
						$urandom_range(0, 99) >= 35)) begin
					head_job = job_queue.pop_front();
					job_ch.valid <= 1'b1;
					job_ch.data  <= head_job.job;
				end else begin
					job_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each result beat against the oldest
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				stats_seen++;
				if (stats_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result beat idx=%0d ct=%0d tat=%0d wt=%0d last=%0b",
							$realtime, res_ch.data.process_index,
							res_ch.data.completion_time, res_ch.data.turnaround_time,
							res_ch.data.waiting_time, res_ch.data.last_result);
				end else begin
					want = stats_pending.pop_front();
					field_bad = (res_ch.data.process_index !== want.process_index) ||
						(res_ch.data.completion_time !== want.completion_time) ||
						(res_ch.data.turnaround_time !== want.turnaround_time) ||
						(res_ch.data.waiting_time !== want.waiting_time) ||
						(res_ch.data.last_result !== want.last_result);
					if (field_bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected idx=%0d ct=%0d tat=%0d wt=%0d last=%0b",
								want.process_index, want.completion_time,
								want.turnaround_time, want.waiting_time, want.last_result);
							$display("  actual   idx=%0d ct=%0d tat=%0d wt=%0d last=%0b",
								res_ch.data.process_index, res_ch.data.completion_time,
								res_ch.data.turnaround_time, res_ch.data.waiting_time,
								res_ch.data.last_result);
						end
					end
				end
			end
			res_ch.ready <= (stats_seen >= 200 && stats_seen < 400) ||
				$urandom_range(0, 99) >= 35;
		end
	end

	// Watchdog: end the run after too long without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int mode;
		int n;
		int roll;
		arst_n = 1'b0;
		set_count = 0;
		set_overflowed = 1'b0;
		beats_sent = 0;
		stats_seen = 0;
		sets_run = 0;
		overflow_sets = 0;
		mismatches = 0;
		quiet_cycles = 0;

		// single processes at the field extremes, zero burst served as one
		add_job(0, 1, 0, 1'b1);
		add_job(65535, 65535, 255, 1'b1);
		add_job(5, 0, 3, 1'b1);

		// preemption, priority ties on arrival and on index, then an idle gap
		add_job(0, 10, 5, 1'b0, 1'b1);
		add_job(3, 2, 1, 1'b0);
		add_job(3, 2, 1, 1'b0);
		add_job(8, 3, 2, 1'b0);
		add_job(6, 3, 2, 1'b0);
		add_job(200, 3, 0, 1'b1);

		// full set plus one dropped beat that still starts the run
		for (int i = 0; i < MAX_JOBS + 1; i++)
			add_job($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 255), i == MAX_JOBS);

		// random sets up to the beat budget: mostly well-formed, some overflowing
		n = RAND_BEATS;
		while (job_queue.size() < n) begin
			roll = $urandom_range(0, 99);
			mode = $urandom_range(0, 3);
			if (roll < 8)
				roll = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
			else if (roll < 20)
				roll = 1;
			else
				roll = $urandom_range(2, MAX_JOBS);
			for (int i = 0; i < roll; i++) begin
				case (mode)
					0: add_job($urandom_range(0, 30), $urandom_range(1, 12),
						$urandom_range(0, 3), i == roll - 1,
						i == 0 && $urandom_range(0, 7) == 0);
					1: add_job($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 255), i == roll - 1);
					2: add_job($urandom_range(0, 5), $urandom_range(0, 4),
						$urandom_range(0, 1), i == roll - 1);
					default: add_job($urandom_range(0, 2000), $urandom_range(1, 100),
						$urandom_range(0, 255), i == roll - 1);
				endcase
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything sent, every statistic back, then let it settle
		while (job_queue.size() > 0 || job_ch.valid || stats_pending.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Ran %0d process sets (%0d with dropped beats): %0d job beats, %0d result beats",
			sets_run, overflow_sets, beats_sent, stats_seen);
		$display("Mismatches: %0d, statistics never returned: %0d",
			mismatches, stats_pending.size());
		if (mismatches == 0 && stats_pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
